[rtl/jerhq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jerhq_pkg;

    localparam int unsigned BTN_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_FIRST_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_NEXT_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME          = 2'd2;

    // Sign bit of the hold timer: set after decrement means expired
    localparam logic [BTN_W-1:0] HOLD_EXPIRE_MASK = 16'h8000;

    typedef logic [BTN_W-1:0] btn_word_t;

    typedef struct packed {
        btn_word_t pad_one_sample;
        btn_word_t pad_two_sample;
    } sample_item_t;

    typedef struct packed {
        btn_word_t pad_one_held;
        btn_word_t pad_one_pressed;
        btn_word_t pad_one_repeat;
        btn_word_t pad_two_held;
        btn_word_t pad_two_pressed;
        btn_word_t pad_two_repeat;
        btn_word_t long_held_set;
        btn_word_t long_held_new;
    } report_item_t;

    typedef struct packed {
        btn_word_t pressed;
        btn_word_t rep_word;
        btn_word_t count;
    } pad_edge_t;

    // Edge detect and auto-repeat countdown for one pad
    function automatic pad_edge_t pad_edge_step(
        input btn_word_t now,
        input btn_word_t prev,
        input btn_word_t count,
        input btn_word_t first_delay,
        input btn_word_t next_delay
    );
        pad_edge_t res;
        btn_word_t dec;
        logic      same_nz;
        logic      expire;
        dec     = count - 16'd1;
        same_nz = (now != '0) && (now == prev);
        expire  = same_nz && (dec == '0);
        res.pressed  = now & (prev ^ now);
        res.rep_word = expire ? now : res.pressed;
        if (!same_nz)
        begin
            res.count = first_delay;
        end
        else if (expire)
        begin
            res.count = next_delay;
        end
        else
        begin
            res.count = dec;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/jerhq_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface jerhq_sample_if
    import jerhq_pkg::*;
;
    logic         valid;
    logic         ready;
    sample_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jerhq_report_if
    import jerhq_pkg::*;
;
    logic         valid;
    logic         ready;
    report_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/joypad_edge_repeat_hold_qualifier.sv]
`timescale 1ns / 1ps
`default_nettype none

// Path: a taken sample request is held in the sample register, then moves into the
//   report register when that frees; the report is held there while the sink holds
//   off, and the sample register waits behind it.
// Throughput: one sample request per cycle, sustained while the sink takes reports.
// Reset: rst_n clears all valid flags, edge history, counters and latches to zero,
//   and the three configuration registers to zero.
module joypad_edge_repeat_hold_qualifier
    import jerhq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    jerhq_sample_if.sink               samples,
    jerhq_report_if.source             reports,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    btn_word_t repeat_first_delay_reg;
    btn_word_t repeat_next_delay_reg;
    btn_word_t hold_time_reg;

    // Sample register stage
    logic         s1_valid_reg;
    sample_item_t s1_data_reg;

    // Report register stage
    logic         out_valid_reg;
    report_item_t out_data_reg;
    report_item_t out_data_next;

    // Per-frame history
    btn_word_t pad_one_prev_reg,   pad_one_prev_next;
    btn_word_t pad_two_prev_reg,   pad_two_prev_next;
    btn_word_t pad_one_count_reg,  pad_one_count_next;
    btn_word_t pad_two_count_reg,  pad_two_count_next;
    btn_word_t settled_reg,        settled_next;
    btn_word_t hold_count_reg,     hold_count_next;
    btn_word_t latched_reg,        latched_next;
    btn_word_t prev_latched_reg,   prev_latched_next;

    logic      out_free;
    logic      advance;
    logic      in_accept;
    pad_edge_t one_edge;
    pad_edge_t two_edge;
    btn_word_t hold_dec;

    // The report register frees when empty or when its request is taken this cycle.
    // Then the sample register moves in; a request can enter every unstalled cycle.
    assign out_free      = !out_valid_reg || reports.ready;
    assign advance       = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || out_free;
    assign in_accept     = samples.valid && samples.ready;

    assign reports.valid = out_valid_reg;
    assign reports.data  = out_data_reg;

    // Configuration writes; indexes past the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_first_delay_reg <= '0;
            repeat_next_delay_reg  <= '0;
            hold_time_reg          <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REPEAT_FIRST_DELAY: repeat_first_delay_reg <= cfg_data;
                CFG_REPEAT_NEXT_DELAY:  repeat_next_delay_reg  <= cfg_data;
                CFG_HOLD_TIME:          hold_time_reg          <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Frame logic: edges, auto-repeat and the stable-hold latch, all from the
    // sample register and the history registers.
    always_comb
    begin
        one_edge = pad_edge_step(s1_data_reg.pad_one_sample, pad_one_prev_reg,
                                 pad_one_count_reg, repeat_first_delay_reg,
                                 repeat_next_delay_reg);
        two_edge = pad_edge_step(s1_data_reg.pad_two_sample, pad_two_prev_reg,
                                 pad_two_count_reg, repeat_first_delay_reg,
                                 repeat_next_delay_reg);

        pad_one_prev_next  = s1_data_reg.pad_one_sample;
        pad_two_prev_next  = s1_data_reg.pad_two_sample;
        pad_one_count_next = one_edge.count;
        pad_two_count_next = two_edge.count;

        // Settled set: held, but not newly pressed this frame
        settled_next      = s1_data_reg.pad_one_sample & ~one_edge.pressed;
        hold_dec          = hold_count_reg - 16'd1;
        prev_latched_next = prev_latched_reg;

        if (settled_next != settled_reg)
        begin
            // Set changed: reload the timer and drop the latch
            hold_count_next = hold_time_reg;
            latched_next    = '0;
        end
        else if ((hold_dec & HOLD_EXPIRE_MASK) == '0)
        begin
            // Still counting down
            hold_count_next = hold_dec;
            latched_next    = '0;
        end
        else
        begin
            // Timer ran out: latch the set and remember the previous latch
            hold_count_next   = '0;
            prev_latched_next = latched_reg;
            latched_next      = settled_next;
        end

        out_data_next.pad_one_held    = s1_data_reg.pad_one_sample;
        out_data_next.pad_one_pressed = one_edge.pressed;
        out_data_next.pad_one_repeat  = one_edge.rep_word;
        out_data_next.pad_two_held    = s1_data_reg.pad_two_sample;
        out_data_next.pad_two_pressed = two_edge.pressed;
        out_data_next.pad_two_repeat  = two_edge.rep_word;
        out_data_next.long_held_set   = latched_next;
        out_data_next.long_held_new   = latched_next & ~prev_latched_next;
    end

    // Valid flags and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            pad_one_prev_reg  <= '0;
            pad_two_prev_reg  <= '0;
            pad_one_count_reg <= '0;
            pad_two_count_reg <= '0;
            settled_reg       <= '0;
            hold_count_reg    <= '0;
            latched_reg       <= '0;
            prev_latched_reg  <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (reports.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Commit history only when a frame moves into the report register
            if (advance)
            begin
                pad_one_prev_reg  <= pad_one_prev_next;
                pad_two_prev_reg  <= pad_two_prev_next;
                pad_one_count_reg <= pad_one_count_next;
                pad_two_count_reg <= pad_two_count_next;
                settled_reg       <= settled_next;
                hold_count_reg    <= hold_count_next;
                latched_reg       <= latched_next;
                prev_latched_reg  <= prev_latched_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= samples.data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_new_latch_subset: assert property (@(posedge clk) disable iff (!rst_n)
        reports.valid |-> ((reports.data.long_held_new & ~reports.data.long_held_set) == '0))
        else $error("long_held_new has bits outside long_held_set");

    a_latch_from_held: assert property (@(posedge clk) disable iff (!rst_n)
        reports.valid |->
            ((reports.data.long_held_set & ~reports.data.pad_one_held) == '0))
        else $error("long_held_set has bits not held on pad one");

    a_pressed_subset: assert property (@(posedge clk) disable iff (!rst_n)
        reports.valid |->
            (((reports.data.pad_one_pressed & ~reports.data.pad_one_held) == '0) &&
             ((reports.data.pad_two_pressed & ~reports.data.pad_two_held) == '0)))
        else $error("pressed bits not held");

    a_sample_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("stalled sample register lost its frame");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

// Frame-by-frame check of the joypad edge, auto-repeat and stable-hold block.
// A sender offers one sample pair per request with random gaps. A sink takes
// reports with random stalls. Each accepted sample runs through a local copy of
// the edge, repeat and hold logic. The report that comes out is compared word
// by word against the oldest prediction still queued.
module testbench;

    import jerhq_pkg::*;

    // Sample to report is two register stages
    localparam int PIPE_LATENCY = 2;
    // Cycles without any request moving before the run is called hung
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_MAX = 13;
    localparam int RANDOM_FRAMES_PER_PHASE = 100;

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    jerhq_sample_if sample_ch ();
    jerhq_report_if report_ch ();

    joypad_edge_repeat_hold_qualifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .reports   (report_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Local copy of the block: registers and per-frame state
    // ------------------------------------------------------------------
    btn_word_t first_delay_reg;
    btn_word_t next_delay_reg;
    btn_word_t hold_time_reg;

    btn_word_t last_word [2];
    btn_word_t repeat_timer [2];
    btn_word_t prior_settled;
    btn_word_t hold_timer;
    btn_word_t latch_word;
    btn_word_t prior_latch;

    report_item_t expected_reports [$];

    int  mismatch_count = 0;
    bit  tx_idle = 1'b0;
    bit  rx_idle = 1'b0;
    int  rx_holdoff_cycles = 0;

    // Edge detect and repeat countdown for one pad; advance that pad's state
    function automatic void pad_edge_predict(input int pad, input btn_word_t now,
                                             output btn_word_t pressed,
                                             output btn_word_t rep_word);
        pressed  = now & (last_word[pad] ^ now);
        rep_word = pressed;
        if (now != '0 && now == last_word[pad])
        begin
            repeat_timer[pad] = repeat_timer[pad] - 16'd1;
            // Expiry: report the whole held set, reload with the next delay
            if (repeat_timer[pad] == '0)
            begin
                rep_word          = now;
                repeat_timer[pad] = next_delay_reg;
            end
        end
        else
        begin
            // Word changed or released: restart from the first delay
            repeat_timer[pad] = first_delay_reg;
        end
        last_word[pad] = now;
    endfunction

    function automatic report_item_t predict_report(input sample_item_t frame);
        report_item_t rpt;
        btn_word_t    settled;
        btn_word_t    pressed;
        btn_word_t    rep_word;
        pad_edge_predict(0, frame.pad_one_sample, pressed, rep_word);
        rpt.pad_one_held    = frame.pad_one_sample;
        rpt.pad_one_pressed = pressed;
        rpt.pad_one_repeat  = rep_word;
        pad_edge_predict(1, frame.pad_two_sample, pressed, rep_word);
        rpt.pad_two_held    = frame.pad_two_sample;
        rpt.pad_two_pressed = pressed;
        rpt.pad_two_repeat  = rep_word;

        // Settled set: pad one buttons down but not newly pressed
        settled = frame.pad_one_sample & ~rpt.pad_one_pressed;
        if (settled != prior_settled)
        begin
            hold_timer = hold_time_reg;
            latch_word = '0;
        end
        else
        begin
            hold_timer = hold_timer - 16'd1;
            if ((hold_timer & HOLD_EXPIRE_MASK) == '0)
            begin
                latch_word = '0;
            end
            else
            begin
                // Timer went negative: latch, keep the old latch for the diff
                hold_timer  = '0;
                prior_latch = latch_word;
                latch_word  = settled;
            end
        end
        prior_settled = settled;

        rpt.long_held_set = latch_word;
        rpt.long_held_new = latch_word & (prior_latch ^ latch_word);
        return rpt;
    endfunction

    // ------------------------------------------------------------------
    // Error bookkeeping: print the first ten, count the rest
    // ------------------------------------------------------------------
    function automatic void log_error(input string msg);
        if (mismatch_count < 10)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_count++;
    endfunction

    function automatic void compare_field(input string name, input btn_word_t got,
                                          input btn_word_t want);
        if (got !== want)
        begin
            log_error($sformatf("%s expected %04h got %04h", name, want, got));
        end
    endfunction

    // ------------------------------------------------------------------
    // Report sink: check each report, then draw a stall when rx_idle is set; the
    // hold-off request from the test sequence overrides the drawn stall
    // ------------------------------------------------------------------
    initial
    begin : report_sink
        int           stall_left;
        report_item_t got;
        report_item_t want;
        stall_left      = 0;
        report_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && report_ch.valid && report_ch.ready)
            begin
                got = report_ch.data;
                if (expected_reports.size() == 0)
                begin
                    log_error($sformatf("report with nothing expected: %h", got));
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("pad_one_held",    got.pad_one_held,    want.pad_one_held);
                    compare_field("pad_one_pressed", got.pad_one_pressed, want.pad_one_pressed);
                    compare_field("pad_one_repeat",  got.pad_one_repeat,  want.pad_one_repeat);
                    compare_field("pad_two_held",    got.pad_two_held,    want.pad_two_held);
                    compare_field("pad_two_pressed", got.pad_two_pressed, want.pad_two_pressed);
                    compare_field("pad_two_repeat",  got.pad_two_repeat,  want.pad_two_repeat);
                    compare_field("long_held_set",   got.long_held_set,   want.long_held_set);
                    compare_field("long_held_new",   got.long_held_new,   want.long_held_new);
                end
                if (rx_idle)
                begin
                    stall_left = $urandom_range(0, IDLE_MAX);
                end
            end
            if (rx_holdoff_cycles > 0)
            begin
                stall_left        = rx_holdoff_cycles;
                rx_holdoff_cycles = 0;
            end
            // One nonblocking write to ready per edge
            if (stall_left > 0)
            begin
                report_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                report_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no request moves on either side for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (report_ch.valid && report_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared sender: optional gap, offer the request, hold until taken,
    // then queue its prediction. Valid stays high into the next request
    // when there is no gap.
    // ------------------------------------------------------------------
    task automatic send_frame(input btn_word_t pad_one, input btn_word_t pad_two);
        int           gap;
        sample_item_t frame;
        gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame.pad_one_sample = pad_one;
        frame.pad_two_sample = pad_two;
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= frame;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        expected_reports.push_back(predict_report(frame));
    endtask

    // Drop valid and wait until every queued report has come back
    task automatic drain_reports();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write all three registers with the block idle; update the local copy
    task automatic program_regs(input btn_word_t first_delay, input btn_word_t next_delay,
                                input btn_word_t hold);
        drain_reports();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REPEAT_FIRST_DELAY;
        cfg_data  <= first_delay;
        @(posedge clk);
        cfg_index <= CFG_REPEAT_NEXT_DELAY;
        cfg_data  <= next_delay;
        @(posedge clk);
        cfg_index <= CFG_HOLD_TIME;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_we <= 1'b0;
        first_delay_reg = first_delay;
        next_delay_reg  = next_delay;
        hold_time_reg   = hold;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers still at reset: zero delays wrap, zero hold latches at once
    task automatic test_reset_registers();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_frame(16'h0000, 16'h0000);
        send_frame(16'hFFFF, 16'h0001);
        send_frame(16'hFFFF, 16'h0001);
        send_frame(16'h8000, 16'hFFFF);
    endtask

    // Press, hold through first and next repeat, add a button, release all
    task automatic test_edges_and_repeat();
        program_regs(16'd2, 16'd1, 16'd2);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_frame(16'h0001, 16'h8000);
        send_frame(16'h0001, 16'h8000);
        send_frame(16'h0001, 16'h8000);
        send_frame(16'h0001, 16'h8000);
        send_frame(16'h0003, 16'h8000);
        send_frame(16'h0000, 16'h0000);
        send_frame(16'hAAAA, 16'h5555);
        send_frame(16'h5555, 16'hAAAA);
    endtask

    // Largest and smallest delays, and hold times at and around the sign bit
    task automatic test_register_extremes();
        program_regs(16'hFFFF, 16'h0000, 16'h0001);
        send_frame(16'h1234, 16'h4321);
        send_frame(16'h1234, 16'h4321);
        send_frame(16'h1234, 16'h4321);
        // Repeat every frame; a hold at the sign bit does not latch on these frames
        program_regs(16'h0001, 16'h0001, HOLD_EXPIRE_MASK);
        send_frame(16'h00FF, 16'hFF00);
        send_frame(16'h00FF, 16'hFF00);
        send_frame(16'h00FF, 16'hFF00);
        program_regs(16'h0000, 16'hFFFF, 16'hFFFF);
        send_frame(16'hF00F, 16'h0FF0);
        send_frame(16'hF00F, 16'h0FF0);
    endtask

    // Settled set stable long enough to latch, then a new latch with extra bits
    task automatic test_hold_latch();
        program_regs(16'd3, 16'd2, 16'h7FFF);
        program_regs(16'd3, 16'd2, 16'd0);
        send_frame(16'h000F, 16'h0000);
        send_frame(16'h000F, 16'h0000);
        send_frame(16'h000F, 16'h0000);
        send_frame(16'h00FF, 16'h0000);
        send_frame(16'h00FF, 16'h0000);
        send_frame(16'h00FF, 16'h0000);
    endtask

    // Runs of held words with sparse extra presses, some noise frames
    task automatic test_random_frames();
        btn_word_t base [2];
        btn_word_t word [2];
        int        run_left [2];
        int        pick;
        run_left[0] = 0;
        run_left[1] = 0;
        base[0]     = '0;
        base[1]     = '0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: program_regs(btn_word_t'($urandom_range(0, 6)),
                                btn_word_t'($urandom_range(0, 6)),
                                btn_word_t'($urandom_range(0, 6)));
                1: program_regs(16'd1, 16'd1, btn_word_t'($urandom_range(0, 3)));
                2: program_regs(btn_word_t'($urandom), btn_word_t'($urandom),
                                btn_word_t'($urandom));
                default: program_regs(btn_word_t'($urandom_range(2, 9)),
                                      btn_word_t'($urandom_range(1, 4)),
                                      btn_word_t'($urandom_range(3, 12)));
            endcase
            // Vary idling per phase, including a stretch with none at all
            tx_idle = (phase == 0) || (phase == 2);
            rx_idle = (phase == 0) || (phase == 3);
            for (int n = 0; n < RANDOM_FRAMES_PER_PHASE; n++)
            begin
                for (int pad = 0; pad < 2; pad++)
                begin
                    if (run_left[pad] == 0)
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick == 0)
                            base[pad] = '0;
                        else if (pick == 1)
                            base[pad] = 16'hFFFF;
                        else
                            base[pad] = btn_word_t'($urandom);
                        run_left[pad] = $urandom_range(1, 12);
                    end
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        word[pad] = base[pad];
                    else if (pick < 9)
                        word[pad] = base[pad] | btn_word_t'($urandom & $urandom & $urandom);
                    else
                        word[pad] = btn_word_t'($urandom);
                    run_left[pad]--;
                end
                send_frame(word[0], word[1]);
            end
        end
    endtask

    // Long sink hold-off while the sender keeps offering back to back,
    // then a full drain before anything else moves
    task automatic test_backpressure();
        program_regs(16'd2, 16'd1, 16'd1);
        tx_idle           = 1'b0;
        rx_idle           = 1'b0;
        rx_holdoff_cycles = 120;
        for (int n = 0; n < 24; n++)
        begin
            send_frame((n % 6 < 4) ? 16'h0C30 : btn_word_t'($urandom),
                       (n % 5 < 3) ? 16'h8001 : btn_word_t'($urandom));
        end
        drain_reports();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_REPEAT_FIRST_DELAY;
        cfg_data        = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;

        // Local copy starts from the reset state
        first_delay_reg = '0;
        next_delay_reg  = '0;
        hold_time_reg   = '0;
        last_word[0]    = '0;
        last_word[1]    = '0;
        repeat_timer[0] = '0;
        repeat_timer[1] = '0;
        prior_settled   = '0;
        hold_timer      = '0;
        latch_word      = '0;
        prior_latch     = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_registers();
        test_edges_and_repeat();
        test_register_extremes();
        test_hold_latch();
        test_random_frames();
        test_backpressure();

        // Let any stray report show up before judging
        drain_reports();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            log_error($sformatf("%0d reports never arrived", expected_reports.size()));
        end

        if (mismatch_count == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
